[src/aerf_pkg.sv]
package aerf_pkg;

   // FIFO geometry
   localparam int FIFO_DEPTH = 1024;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // field widths
   localparam int WORD_W  = 13;
   localparam int TIME_W  = 63;
   localparam int SPAN_W  = 32;
   localparam int ERR_W   = 16;
   localparam int COUNT_W = 10;

   localparam logic [WORD_W-1:0] MIN_VALUE = WORD_W'(2);

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 144;

   typedef enum logic [1:0] {
      MODE_LIVE  = 2'd0,
      MODE_READY = 2'd1,
      MODE_POP   = 2'd2,
      MODE_OTHER = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DEAD  = 2'd1,
      PH_EVENT = 2'd2,
      PH_HANG  = 2'd3
   } phase_type;

   // one stored event
   typedef struct packed {
      logic [ERR_W-1:0]  errors;
      logic [WORD_W-1:0] value;
      logic [SPAN_W-1:0] span;
      logic [TIME_W-1:0] start;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // input item as packed on req_tdata
   typedef struct packed {
      logic [1:0]        pad;
      logic [TIME_W-1:0] time_ns;
      logic [WORD_W-1:0] adc_word;
      logic              ready_level;
      logic              live_level;
   } req_type;

   // result item as packed on rsp_tdata
   typedef struct packed {
      logic [5:0]         pad;
      logic [COUNT_W-1:0] fifo_count;
      logic [1:0]         fsm_state;
      logic [ERR_W-1:0]   event_errors;
      logic [WORD_W-1:0]  event_value;
      logic [SPAN_W-1:0]  event_span;
      logic [TIME_W-1:0]  event_start;
      logic               event_valid;
      logic               ack_pulse;
   } rsp_type;

   // status of an item between the state update and the output register
   typedef struct packed {
      logic               ack_pulse;
      logic               event_valid;
      phase_type          fsm_state;
      logic [COUNT_W-1:0] fifo_count;
   } stage_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

   function automatic logic [COUNT_W-1:0] fifo_level(input logic [PTR_W-1:0] wp,
                                                     input logic [PTR_W-1:0] rp);
      logic [PTR_W:0] occ;
      occ = {1'b0, wp} - {1'b0, rp};
      if (wp < rp) begin
         occ = occ + (PTR_W+1)'(FIFO_DEPTH);
      end
      return COUNT_W'(occ);
   endfunction

endpackage

[src/aerf_ram.sv]
module aerf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_q [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   // registered read, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/adc_event_readout_fifo.sv]
// Readout sequencer for a pulse-height ADC with a circular event FIFO of
// aerf_pkg::FIFO_DEPTH entries (holding at most FIFO_DEPTH-1 events). Each item
// carries a kind on req_tuser (live-time edge, data-ready edge, pop, unknown)
// and returns exactly one result item. The block takes one item per clock
// unless rsp_tready stalls the result side; the result passes through the
// registered read of the event memory, then the output register. All sequencer state
// updates in the accept cycle, and each item touches the single-port-per-side
// event memory at most once, so back-to-back items never conflict.
module adc_event_readout_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, low bit up: live_level(1), ready_level(1), adc_word(13), time_ns(63), zero(2)
   input  logic [aerf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: mode(2)
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata, low bit up: ack_pulse(1), event_valid(1), event_start(63), event_span(32),
   // event_value(13), event_errors(16), fsm_state(2), fifo_count(10), zero(6)
   output logic [aerf_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   aerf_pkg::req_type   req;
   aerf_pkg::mode_type  mode;
   logic                accept;

   aerf_pkg::phase_type phase_ff, phase_in;
   logic [aerf_pkg::TIME_W-1:0] start_ff, start_in;
   logic [aerf_pkg::WORD_W-1:0] sample_ff, sample_in;
   logic [aerf_pkg::ERR_W-1:0]  err_ff, err_in;
   logic [aerf_pkg::PTR_W-1:0]  wp_ff, wp_in;
   logic [aerf_pkg::PTR_W-1:0]  rp_ff, rp_in;

   logic                        full;
   logic                        empty;
   logic [aerf_pkg::WORD_W-1:0] conv_value;
   logic                        ack;
   logic                        pop_hit;
   logic                        wr_en;
   aerf_pkg::entry_type         wr_entry;
   aerf_pkg::entry_type         rd_entry;
   logic [aerf_pkg::ENTRY_W-1:0] rd_data;

   logic                        s1_valid_ff;
   aerf_pkg::stage_type         s1_ff, s1_in;
   logic                        advance;
   logic                        rsp_valid_ff;
   aerf_pkg::rsp_type           rsp_ff, rsp_in;

   assign req    = aerf_pkg::req_type'(req_tdata);
   assign mode   = aerf_pkg::mode_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   assign full  = (aerf_pkg::next_ptr(wp_ff) == rp_ff);
   assign empty = (rp_ff == wp_ff);

   // invert the data pins and clamp to the smallest valid amplitude
   always_comb begin
      conv_value = ~req.adc_word;
      if (conv_value < aerf_pkg::MIN_VALUE) begin
         conv_value = aerf_pkg::MIN_VALUE;
      end
   end

   // sequencer: next state, FIFO access and status of this item
   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      sample_in = sample_ff;
      err_in    = err_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      ack       = 1'b0;
      pop_hit   = 1'b0;
      wr_en     = 1'b0;
      wr_entry.start  = start_ff;
      wr_entry.span   = req.time_ns[aerf_pkg::SPAN_W-1:0] - start_ff[aerf_pkg::SPAN_W-1:0];
      wr_entry.value  = sample_ff;
      wr_entry.errors = err_ff;
      if (accept) begin
         unique case (mode)
            aerf_pkg::MODE_LIVE: begin
               priority case (phase_ff)
                  aerf_pkg::PH_IDLE: begin
                     if (req.live_level) begin
                        err_in = err_ff + aerf_pkg::ERR_W'(1);
                     end else begin
                        start_in = req.time_ns;
                        phase_in = aerf_pkg::PH_DEAD;
                     end
                  end
                  aerf_pkg::PH_EVENT: begin
                     if (!req.live_level) begin
                        err_in = err_ff + aerf_pkg::ERR_W'(1);
                     end else begin
                        // close the dead time: store the event
                        wr_en    = 1'b1;
                        wp_in    = aerf_pkg::next_ptr(wp_ff);
                        err_in   = '0;
                        phase_in = aerf_pkg::PH_IDLE;
                     end
                  end
                  default: begin
                     err_in   = err_ff + aerf_pkg::ERR_W'(1);
                     phase_in = aerf_pkg::PH_IDLE;
                  end
               endcase
            end
            aerf_pkg::MODE_READY: begin
               if (phase_ff == aerf_pkg::PH_DEAD) begin
                  if (req.ready_level) begin
                     err_in = err_ff + aerf_pkg::ERR_W'(1);
                  end else if (full) begin
                     phase_in = aerf_pkg::PH_HANG;
                  end else begin
                     sample_in = conv_value;
                     phase_in  = aerf_pkg::PH_EVENT;
                     ack       = 1'b1;
                  end
               end else begin
                  err_in   = err_ff + aerf_pkg::ERR_W'(1);
                  phase_in = aerf_pkg::PH_IDLE;
               end
            end
            aerf_pkg::MODE_POP: begin
               if (!empty) begin
                  pop_hit = 1'b1;
                  rp_in   = aerf_pkg::next_ptr(rp_ff);
                  // a freed slot lets a hung sample retry
                  if (phase_ff == aerf_pkg::PH_HANG) begin
                     if (!req.ready_level) begin
                        sample_in = conv_value;
                        phase_in  = aerf_pkg::PH_EVENT;
                        ack       = 1'b1;
                     end else begin
                        phase_in = aerf_pkg::PH_IDLE;
                     end
                  end
               end
            end
            aerf_pkg::MODE_OTHER: begin
               err_in = err_ff + aerf_pkg::ERR_W'(1);
            end
         endcase
      end
      s1_in.ack_pulse   = ack;
      s1_in.event_valid = pop_hit;
      s1_in.fsm_state   = phase_in;
      s1_in.fifo_count  = aerf_pkg::fifo_level(wp_in, rp_in);
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= aerf_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         sample_ff <= '0;
         err_ff    <= '0;
         wp_ff     <= '0;
         rp_ff     <= '0;
      end else begin
         start_ff  <= start_in;
         sample_ff <= sample_in;
         err_ff    <= err_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
      end
   end

   aerf_ram #(
      .WIDTH(aerf_pkg::ENTRY_W),
      .DEPTH(aerf_pkg::FIFO_DEPTH)
   ) u_event_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wp_ff),
      .wr_data(wr_entry),
      .rd_en  (pop_hit),
      .rd_addr(rp_ff),
      .rd_data(rd_data)
   );

   assign rd_entry = aerf_pkg::entry_type'(rd_data);

   // merge status with read data; zero event fields when nothing popped
   always_comb begin
      rsp_in              = '0;
      rsp_in.ack_pulse    = s1_ff.ack_pulse;
      rsp_in.event_valid  = s1_ff.event_valid;
      rsp_in.fsm_state    = s1_ff.fsm_state;
      rsp_in.fifo_count   = s1_ff.fifo_count;
      if (s1_ff.event_valid) begin
         rsp_in.event_start  = rd_entry.start;
         rsp_in.event_span   = rd_entry.span;
         rsp_in.event_value  = rd_entry.value;
         rsp_in.event_errors = rd_entry.errors;
      end
   end

   // advance the status stage and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= accept;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (advance && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // a store never lands on an unread entry
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (aerf_pkg::next_ptr(wp_ff) != rp_ff))
      else $error("event store into full FIFO");

   // a pop only reads written entries
   assert property (@(posedge clock) disable iff (reset)
      pop_hit |-> (rp_ff != wp_ff))
      else $error("pop from empty FIFO");

   // hang is held only while the FIFO is full
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == aerf_pkg::PH_HANG) |-> full)
      else $error("hang phase with free FIFO slot");

   // an acknowledge always leaves the sequencer in the event phase
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.ack_pulse) |-> (rsp_ff.fsm_state == aerf_pkg::PH_EVENT))
      else $error("acknowledge outside event phase");

   // a stalled status stage keeps its read data
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> $stable(rd_data))
      else $error("event read data lost during stall");

endmodule

[sim/adc_event_readout_fifo_checker.sv]
// Watches both streams of the ADC readout sequencer, predicts every result
// item from the accepted input items and compares them field by field.
module adc_event_readout_fifo_checker
   import aerf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     failures,
   output int                     pending,
   output int                     items_seen,
   output int                     results_seen,
   output int                     events_read,
   output int                     hang_count,
   output int                     ack_count
);

   // predicted sequencer state
   phase_type          seq_phase;
   logic [TIME_W-1:0]  dead_start;
   logic [WORD_W-1:0]  held_sample;
   logic [ERR_W-1:0]   fault_count;
   logic [PTR_W-1:0]   wr_index;
   logic [PTR_W-1:0]   rd_index;
   entry_type          event_store [FIFO_DEPTH];

   // results still to come, oldest first
   rsp_type            readout_due [$];

   int                 mismatch_total = 0;
   int                 item_total = 0;
   int                 result_total = 0;
   int                 popped_total = 0;
   int                 hang_total = 0;
   int                 ack_total = 0;

   function automatic logic [PTR_W-1:0] wrap_index(input logic [PTR_W-1:0] p);
      return PTR_W'((int'(p) + 1) % FIFO_DEPTH);
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch: result %0d field %s got %h, predicted %h",
               result_total, field, got, want);
      mismatch_total++;
   endtask

   task automatic count_fault();
      fault_count = fault_count + ERR_W'(1);
   endtask

   // invert the raw word, clamp low values and move to the event phase
   task automatic take_sample(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] amp;
      amp = ~word;
      if (amp < MIN_VALUE) begin
         amp = MIN_VALUE;
      end
      held_sample = amp;
      seq_phase   = PH_EVENT;
   endtask

   // advance the predicted sequencer by one input item
   task automatic advance_readout(input mode_type kind, input req_type item,
                                  output rsp_type res);
      entry_type ev;
      res = '0;
      case (kind)
         MODE_LIVE: begin
            if (seq_phase == PH_IDLE) begin
               if (item.live_level) begin
                  count_fault();
               end else begin
                  dead_start = item.time_ns;
                  seq_phase  = PH_DEAD;
               end
            end else if (seq_phase == PH_EVENT) begin
               if (!item.live_level) begin
                  count_fault();
               end else begin
                  ev.start  = dead_start;
                  ev.span   = SPAN_W'(item.time_ns - dead_start);
                  ev.value  = held_sample;
                  ev.errors = fault_count;
                  event_store[wr_index] = ev;
                  wr_index    = wrap_index(wr_index);
                  fault_count = '0;
                  seq_phase   = PH_IDLE;
               end
            end else begin
               count_fault();
               seq_phase = PH_IDLE;
            end
         end
         MODE_READY: begin
            if (seq_phase == PH_DEAD) begin
               if (item.ready_level) begin
                  count_fault();
               end else if (wrap_index(wr_index) == rd_index) begin
                  seq_phase = PH_HANG;
                  hang_total++;
               end else begin
                  take_sample(item.adc_word);
                  res.ack_pulse = 1'b1;
               end
            end else begin
               count_fault();
               seq_phase = PH_IDLE;
            end
         end
         MODE_POP: begin
            if (rd_index != wr_index) begin
               ev = event_store[rd_index];
               res.event_valid  = 1'b1;
               res.event_start  = ev.start;
               res.event_span   = ev.span;
               res.event_value  = ev.value;
               res.event_errors = ev.errors;
               rd_index = wrap_index(rd_index);
               popped_total++;
               // a freed slot lets a hung sample through
               if (seq_phase == PH_HANG) begin
                  if (!item.ready_level) begin
                     take_sample(item.adc_word);
                     res.ack_pulse = 1'b1;
                  end else begin
                     seq_phase = PH_IDLE;
                  end
               end
            end
         end
         default: begin
            count_fault();
         end
      endcase
      if (res.ack_pulse) begin
         ack_total++;
      end
      res.fsm_state  = seq_phase;
      res.fifo_count = COUNT_W'((int'(wr_index) + FIFO_DEPTH - int'(rd_index)) % FIFO_DEPTH);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         seq_phase   = PH_IDLE;
         dead_start  = '0;
         held_sample = '0;
         fault_count = '0;
         wr_index    = '0;
         rd_index    = '0;
         readout_due.delete();
      end else begin
         // predict on every accepted input item
         if (req_tvalid && req_tready) begin
            advance_readout(mode_type'(req_tuser), req_type'(req_tdata), want);
            readout_due.push_back(want);
            item_total++;
         end
         // compare every accepted result item with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            if (readout_due.size() == 0) begin
               report_mismatch("unexpected_result", rsp_tdata[63:0], '0);
            end else begin
               want = readout_due.pop_front();
               if (got.ack_pulse !== want.ack_pulse)
                  report_mismatch("ack_pulse", got.ack_pulse, want.ack_pulse);
               if (got.event_valid !== want.event_valid)
                  report_mismatch("event_valid", got.event_valid, want.event_valid);
               if (got.event_start !== want.event_start)
                  report_mismatch("event_start", got.event_start, want.event_start);
               if (got.event_span !== want.event_span)
                  report_mismatch("event_span", got.event_span, want.event_span);
               if (got.event_value !== want.event_value)
                  report_mismatch("event_value", got.event_value, want.event_value);
               if (got.event_errors !== want.event_errors)
                  report_mismatch("event_errors", got.event_errors, want.event_errors);
               if (got.fsm_state !== want.fsm_state)
                  report_mismatch("fsm_state", got.fsm_state, want.fsm_state);
               if (got.fifo_count !== want.fifo_count)
                  report_mismatch("fifo_count", got.fifo_count, want.fifo_count);
               if (got.pad !== want.pad)
                  report_mismatch("zero_fill", got.pad, want.pad);
            end
            result_total++;
         end
      end
      // publish counters once per edge
      failures     <= mismatch_total;
      pending      <= readout_due.size();
      items_seen   <= item_total;
      results_seen <= result_total;
      events_read  <= popped_total;
      hang_count   <= hang_total;
      ack_count    <= ack_total;
   end

endmodule

[sim/adc_event_readout_fifo_tb.sv]
// Stimulus and verdict for the ADC readout sequencer; checking lives in the
// checker instance beside the block.
module adc_event_readout_fifo_tb;
   import aerf_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 520;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = MODE_LIVE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic                   send_calm = 1'b0;
   logic                   recv_calm = 1'b0;
   int                     recv_hold = 0;
   int                     quiet_cycles = 0;
   int                     sent = 0;

   int                     failures;
   int                     pending;
   int                     items_seen;
   int                     results_seen;
   int                     events_read;
   int                     hang_count;
   int                     ack_count;

   always #6 clock = ~clock;

   adc_event_readout_fifo DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   adc_event_readout_fifo_checker readout_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .failures     (failures),
      .pending      (pending),
      .items_seen   (items_seen),
      .results_seen (results_seen),
      .events_read  (events_read),
      .hang_count   (hang_count),
      .ack_count    (ack_count)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(25, 60);
   endfunction

   function automatic logic [TIME_W-1:0] rand_stamp();
      return TIME_W'({$urandom(), $urandom()});
   endfunction

   // dead-time length: short, 32-bit, beyond 32 bits, or running backwards
   function automatic logic [TIME_W-1:0] rand_span();
      case ($urandom_range(0, 3))
         0: return TIME_W'($urandom_range(0, 1000));
         1: return TIME_W'($urandom());
         default: return rand_stamp();
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return WORD_W'($urandom_range(8189, 8191));
         1: return '0;
         default: return WORD_W'($urandom());
      endcase
   endfunction

   // throttle the result side
   always @(posedge clock) begin
      if (recv_hold > 0) begin
         recv_hold  <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
         recv_hold  <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // present one item and hold it until accepted
   task automatic send_item(input mode_type kind, input logic live, input logic rdy,
                            input logic [WORD_W-1:0] word, input logic [TIME_W-1:0] stamp);
      req_type item;
      int      gap;
      gap = (!send_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item             = '0;
      item.live_level  = live;
      item.ready_level = rdy;
      item.adc_word    = word;
      item.time_ns     = stamp;
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic send_noise();
      send_item(mode_type'($urandom_range(0, 3)), 1'($urandom()), 1'($urandom()),
                rand_word(), rand_stamp());
   endtask

   task automatic send_pop(input logic rdy, input logic [WORD_W-1:0] word);
      send_item(MODE_POP, 1'($urandom()), rdy, word, rand_stamp());
   endtask

   // open dead time and present a sample
   task automatic open_and_sample(input logic [WORD_W-1:0] word,
                                  input logic [TIME_W-1:0] opened);
      send_item(MODE_LIVE, 1'b0, 1'($urandom()), rand_word(), opened);
      send_item(MODE_READY, 1'($urandom()), 1'b0, word, rand_stamp());
   endtask

   // a complete well-formed event
   task automatic send_event(input logic [WORD_W-1:0] word, input logic [TIME_W-1:0] opened,
                             input logic [TIME_W-1:0] span);
      open_and_sample(word, opened);
      send_item(MODE_LIVE, 1'b1, 1'($urandom()), rand_word(), opened + span);
   endtask

   // stop sending until every result is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int            start_count;
      int            choice;
      logic [TIME_W-1:0] opened;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wrong levels, bad transitions and an empty pop
      send_item(MODE_LIVE, 1'b1, 1'b0, 13'h0000, '0);
      send_item(MODE_OTHER, 1'b0, 1'b1, 13'h1fff, '1);
      send_item(MODE_READY, 1'b0, 1'b0, 13'h0abc, '0);
      send_pop(1'b0, 13'h1fff);
      send_item(MODE_LIVE, 1'b0, 1'b1, 13'h1555, '0);
      send_item(MODE_READY, 1'b0, 1'b1, 13'h0aaa, '1);
      send_item(MODE_LIVE, 1'b0, 1'b0, 13'h0000, TIME_W'(77));
      // all-ones word clamps to the minimum; span wraps past the top
      send_item(MODE_LIVE, 1'b0, 1'b0, 13'h0000, '1);
      send_item(MODE_READY, 1'b1, 1'b0, 13'h1fff, '0);
      send_item(MODE_LIVE, 1'b1, 1'b1, 13'h1fff, TIME_W'(5));
      // inverted value one clamps too; low level while an event is held
      send_item(MODE_LIVE, 1'b0, 1'b0, 13'h0000, '0);
      send_item(MODE_READY, 1'b0, 1'b0, 13'h1ffe, TIME_W'(3));
      send_item(MODE_LIVE, 1'b0, 1'b0, 13'h0000, TIME_W'(9));
      send_item(MODE_LIVE, 1'b1, 1'b0, 13'h0000, '1);
      // ready edge while an event is held
      send_item(MODE_LIVE, 1'b0, 1'b1, 13'h1234, rand_stamp());
      send_item(MODE_READY, 1'b1, 1'b0, 13'h0000, '0);
      send_item(MODE_READY, 1'b1, 1'b0, 13'h0000, '0);
      send_event(13'h1ffd, rand_stamp(), rand_span());
      repeat (4) send_pop(1'b1, 13'h0000);
      wait_for_results();

      // random traffic: mostly well-formed events, some pops and noise
      start_count = sent;
      while (sent - start_count < RANDOM_ITEMS) begin
         if ((sent - start_count) % 40 == 0) begin
            send_calm <= ($urandom_range(0, 3) == 0);
            recv_calm <= ($urandom_range(0, 3) == 0);
         end
         choice = $urandom_range(0, 99);
         if (choice < 60) begin
            send_event(rand_word(), rand_stamp(), rand_span());
            if ($urandom_range(0, 2) == 0) begin
               send_pop(1'($urandom()), rand_word());
            end
         end else if (choice < 75) begin
            send_pop(1'($urandom()), rand_word());
         end else if (choice < 88) begin
            // broken sequence: open, then anything
            opened = rand_stamp();
            if ($urandom_range(0, 1) == 0) begin
               send_item(MODE_LIVE, 1'b0, 1'($urandom()), rand_word(), opened);
            end else begin
               open_and_sample(rand_word(), opened);
            end
            send_noise();
         end else begin
            send_noise();
         end
         if (sent - start_count > RANDOM_ITEMS / 2 && sent - start_count < RANDOM_ITEMS / 2 + 4)
         begin
            wait_for_results();
         end
      end
      send_calm <= 1'b0;
      recv_calm <= 1'b0;

      wait_for_results();
      repeat (6) @(posedge clock);
      $display("summary: %0d items in, %0d results checked, %0d events read back",
               items_seen, results_seen, events_read);
      $display("summary: %0d samples acknowledged, %0d full-FIFO hangs, %0d mismatches",
               ack_count, hang_count, failures);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
